// ===== sv/edbf_pkg.sv =====
package edbf_pkg;

  // Stream widths: fields packed from bit 0 up, padded to whole bytes.
  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 104;
  localparam int unsigned OUT_TUSER_W = 1;

  // Input tdata: pkt_byte, direction, port_index, blocked_addr (LSB first).
  typedef struct packed {
    logic [6:0]  pad;
    logic [31:0] blocked_addr;
    logic [7:0]  port_index;
    logic        direction;
    logic [7:0]  pkt_byte;
  } in_data_t;

  // Output tdata: drop, out_direction, out_port, pkt_len, cap_len,
  // pkt_count, table_status (LSB first).
  typedef struct packed {
    logic [3:0]  pad;
    logic [1:0]  table_status;
    logic [63:0] pkt_count;
    logic [7:0]  cap_len;
    logic [15:0] pkt_len;
    logic [7:0]  out_port;
    logic        out_direction;
    logic        drop;
  } out_data_t;

  typedef enum logic [1:0] {
    REQ_PKT = 2'd0,
    REQ_ADD = 2'd1,
    REQ_DEL = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_e;

  localparam logic KIND_VERDICT = 1'b0;
  localparam logic KIND_ACK     = 1'b1;

  localparam logic [15:0] ETH_VLAN_Q  = 16'h8100;
  localparam logic [15:0] ETH_VLAN_AD = 16'h88A8;
  localparam logic [15:0] ETH_IPV4    = 16'h0800;
  localparam logic [3:0]  IP_VER4     = 4'd4;

  localparam logic [15:0] POS_MAX     = 16'hFFFF;
  localparam logic [15:0] CAPTURE_MAX = 16'd128;

  // Header offsets
  localparam logic [15:0] OFS_TYPE_HI = 16'd12;
  localparam logic [15:0] OFS_TYPE_LO = 16'd13;
  localparam logic [15:0] OFS_TAG_HI  = 16'd16;
  localparam logic [15:0] OFS_TAG_LO  = 16'd17;
  localparam logic [15:0] L3_UNTAG    = 16'd14;
  localparam logic [15:0] L3_TAG      = 16'd18;
  localparam logic [15:0] OFS_DST     = 16'd16;
  localparam logic [15:0] OFS_DST_END = 16'd19;
  localparam logic [15:0] L3_MIN_LEN  = 16'd20;

endpackage

// ===== sv/egress_ipv4_dest_blocklist_filter_top.sv =====
// Pipeline: two register stages (input register, result register); a result is formed from
// the input register and held in the result register that drives m_axis_tvalid.
// Throughput: one item per cycle, packet bytes and table requests alike; only the
// result register stalls the pipe, and only while m_axis_tready is low.
// Blocklist: TABLE_ENTRIES-entry CAM in flops, all entries compared in parallel.
// Reset (rst_ni low, async): parse state, counters, valid bits and handshake state
// clear at once; no clearing pass, s_axis_tready is high as soon as reset is released.
module egress_ipv4_dest_blocklist_filter_top #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // pkt_byte[7:0], direction[8], port_index[16:9], blocked_addr[48:17], zero pad
  input  logic [edbf_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // req_type[1:0]
  input  logic [edbf_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
  // last_byte
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // drop[0], out_direction[1], out_port[9:2], pkt_len[25:10], cap_len[33:26],
  // pkt_count[97:34], table_status[99:98], zero pad
  output logic [edbf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // result_kind[0]
  output logic [edbf_pkg::OUT_TUSER_W-1:0]    m_axis_tuser
);
  import edbf_pkg::*;

  // ---------------- input register ----------------
  logic                  in_valid_q, in_valid_d;
  logic [IN_TDATA_W-1:0] in_tdata_q;
  logic [IN_TUSER_W-1:0] in_tuser_q;
  logic                  in_tlast_q;

  // ---------------- result register ----------------
  logic                   out_valid_q, out_valid_d;
  out_data_t              out_data_q, out_data_d;
  logic [OUT_TUSER_W-1:0] out_kind_q, out_kind_d;

  // ---------------- parse state ----------------
  logic [15:0] pos_q, pos_d;
  logic [15:0] eth_q, eth_d;
  logic        tag_q, tag_d;
  logic [3:0]  ver_q, ver_d;
  logic [31:0] dest_q, dest_d;
  logic        dir_q, dir_d;
  logic [7:0]  port_q, port_d;
  logic [63:0] ing_total_q, ing_total_d;
  logic [63:0] egr_total_q, egr_total_d;

  // ---------------- blocklist CAM ----------------
  logic [31:0]              entry_addr_q [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] entry_valid_q, entry_valid_d;
  logic [TABLE_ENTRIES-1:0] hit_addr_vec, hit_dest_vec, free_oh, add_we;

  // Pipe advances when the result slot is free or being drained this cycle.
  logic advance;
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  in_data_t in_d;
  req_e     req;
  logic     first, hit_addr, hit_dest, full;
  logic [15:0] eth0, eth1, eth2, l3, pos_next;
  logic        tag0, tag1;
  logic [3:0]  ver0, ver1;
  logic [31:0] dest0, dest1;
  logic        dir_v;
  logic [7:0]  port_v;
  logic        drop;
  logic [63:0] cnt;
  logic [15:0] cap;

  assign in_d = in_data_t'(in_tdata_q);
  assign req  = req_e'(in_tuser_q);

  // Byte parser: each stage of the header update is one mux on the last.
  always_comb begin
    first  = (pos_q == '0);
    dir_v  = first ? in_d.direction  : dir_q;
    port_v = first ? in_d.port_index : port_q;
    eth0   = first ? '0 : eth_q;
    tag0   = first ? 1'b0 : tag_q;
    ver0   = first ? '0 : ver_q;
    dest0  = first ? '0 : dest_q;

    eth1 = eth0;
    if (pos_q == OFS_TYPE_HI || (tag0 && pos_q == OFS_TAG_HI)) begin
      eth1 = {in_d.pkt_byte, eth0[7:0]};
    end
    eth2 = eth1;
    if (pos_q == OFS_TYPE_LO || (tag0 && pos_q == OFS_TAG_LO)) begin
      eth2 = {eth1[15:8], in_d.pkt_byte};
    end
    tag1 = tag0 || (pos_q == OFS_TYPE_LO &&
                    (eth2 == ETH_VLAN_Q || eth2 == ETH_VLAN_AD));
    l3   = tag1 ? L3_TAG : L3_UNTAG;
    ver1 = (pos_q == l3) ? in_d.pkt_byte[7:4] : ver0;
    dest1 = dest0;
    if (pos_q >= l3 + OFS_DST && pos_q <= l3 + OFS_DST_END) begin
      dest1 = {dest0[23:0], in_d.pkt_byte};
    end
    pos_next = (pos_q != POS_MAX) ? pos_q + 16'd1 : pos_q;
  end

  // CAM compare against the request address and the parsed destination.
  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      hit_addr_vec[i] = entry_valid_q[i] && (entry_addr_q[i] == in_d.blocked_addr);
      hit_dest_vec[i] = entry_valid_q[i] && (entry_addr_q[i] == dest1);
    end
  end
  assign hit_addr = |hit_addr_vec;
  assign hit_dest = |hit_dest_vec;
  assign full     = &entry_valid_q;
  // lowest clear valid bit, one-hot
  assign free_oh  = ~entry_valid_q & (entry_valid_q + TABLE_ENTRIES'(1));

  assign drop = dir_v && (pos_next >= l3 + L3_MIN_LEN) && (eth2 == ETH_IPV4) &&
                (ver1 == IP_VER4) && hit_dest;
  assign cnt  = dir_v ? egr_total_q + 64'd1 : ing_total_q + 64'd1;
  assign cap  = (pos_next > CAPTURE_MAX) ? CAPTURE_MAX : pos_next;

  always_comb begin
    pos_d         = pos_q;
    eth_d         = eth_q;
    tag_d         = tag_q;
    ver_d         = ver_q;
    dest_d        = dest_q;
    dir_d         = dir_q;
    port_d        = port_q;
    ing_total_d   = ing_total_q;
    egr_total_d   = egr_total_q;
    entry_valid_d = entry_valid_q;
    add_we        = '0;
    out_data_d    = out_data_q;
    out_kind_d    = out_kind_q;
    out_valid_d   = out_valid_q && !m_axis_tready;

    if (advance) begin
      unique case (req)
        REQ_PKT: begin
          eth_d  = eth2;
          tag_d  = tag1;
          ver_d  = ver1;
          dest_d = dest1;
          dir_d  = dir_v;
          port_d = port_v;
          pos_d  = in_tlast_q ? '0 : pos_next;
          if (in_tlast_q) begin
            if (dir_v) begin
              egr_total_d = cnt;
            end else begin
              ing_total_d = cnt;
            end
            out_valid_d              = 1'b1;
            out_kind_d               = KIND_VERDICT;
            out_data_d               = '0;
            out_data_d.drop          = drop;
            out_data_d.out_direction = dir_v;
            out_data_d.out_port      = port_v;
            out_data_d.pkt_len       = pos_next;
            out_data_d.cap_len       = cap[7:0];
            out_data_d.pkt_count     = cnt;
            out_data_d.table_status  = ST_OK;
          end
        end
        REQ_ADD: begin
          out_valid_d             = 1'b1;
          out_kind_d              = KIND_ACK;
          out_data_d              = '0;
          out_data_d.table_status = ST_OK;
          if (!hit_addr) begin
            if (full) begin
              out_data_d.table_status = ST_FULL;
            end else begin
              add_we        = free_oh;
              entry_valid_d = entry_valid_q | free_oh;
            end
          end
        end
        REQ_DEL: begin
          out_valid_d             = 1'b1;
          out_kind_d              = KIND_ACK;
          out_data_d              = '0;
          out_data_d.table_status = hit_addr ? ST_OK : ST_MISS;
          entry_valid_d           = entry_valid_q & ~hit_addr_vec;
        end
        default: begin
          // unused request code: consumed, no result
        end
      endcase
    end
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tready) begin
      in_valid_d = s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      pos_q         <= '0;
      eth_q         <= '0;
      tag_q         <= 1'b0;
      ver_q         <= '0;
      dest_q        <= '0;
      dir_q         <= 1'b0;
      port_q        <= '0;
      ing_total_q   <= '0;
      egr_total_q   <= '0;
      entry_valid_q <= '0;
    end else begin
      in_valid_q    <= in_valid_d;
      out_valid_q   <= out_valid_d;
      pos_q         <= pos_d;
      eth_q         <= eth_d;
      tag_q         <= tag_d;
      ver_q         <= ver_d;
      dest_q        <= dest_d;
      dir_q         <= dir_d;
      port_q        <= port_d;
      ing_total_q   <= ing_total_d;
      egr_total_q   <= egr_total_d;
      entry_valid_q <= entry_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_tdata_q <= s_axis_tdata;
      in_tuser_q <= s_axis_tuser;
      in_tlast_q <= s_axis_tlast;
    end
    out_data_q <= out_data_d;
    out_kind_q <= out_kind_d;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (add_we[i]) begin
        entry_addr_q[i] <= in_d.blocked_addr;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_kind_q;

endmodule

// ===== sv/edbf_checker.sv =====
module edbf_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [edbf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input logic [edbf_pkg::OUT_TUSER_W-1:0]    m_axis_tuser
);
  import edbf_pkg::*;

  logic is_ack, is_verdict;
  assign is_ack     = m_axis_tvalid && (m_axis_tuser == KIND_ACK);
  assign is_verdict = m_axis_tvalid && (m_axis_tuser == KIND_VERDICT);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // acks carry only a status, never the unused status code
  a_ack_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_ack |-> (m_axis_tdata[97:0] == '0) && (m_axis_tdata[99:98] != 2'd3))
    else $error("malformed table ack");

  // verdicts: status clear, length at least one byte
  a_verdict_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_verdict |-> (m_axis_tdata[99:98] == ST_OK) && (m_axis_tdata[25:10] != '0))
    else $error("malformed verdict");

  // a drop needs an egress packet long enough to hold an IPv4 destination
  a_drop_egress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_verdict && m_axis_tdata[0] |->
      m_axis_tdata[1] && (m_axis_tdata[25:10] >= 16'd34))
    else $error("drop on ingress or short packet");

endmodule

bind egress_ipv4_dest_blocklist_filter_top edbf_checker u_edbf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/blocklist_filter_checker.sv =====
module blocklist_filter_checker #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_tvalid_i,
  input  logic                             s_tready_i,
  input  logic [edbf_pkg::IN_TDATA_W-1:0]  s_tdata_i,
  input  logic [edbf_pkg::IN_TUSER_W-1:0]  s_tuser_i,
  input  logic                             s_tlast_i,
  input  logic                             m_tvalid_i,
  input  logic                             m_tready_i,
  input  logic [edbf_pkg::OUT_TDATA_W-1:0] m_tdata_i,
  input  logic [edbf_pkg::OUT_TUSER_W-1:0] m_tuser_i,
  output int                               fail_count_o,
  output int                               pending_o,
  output int                               verdicts_o,
  output int                               acks_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import edbf_pkg::*;

  typedef struct {
    logic      kind;
    out_data_t data;
  } filter_result_t;

  filter_result_t results_due[$];

  // parser state
  logic [15:0] byte_pos;
  logic [15:0] eth_type;
  logic        tag_seen;
  logic [3:0]  ip_ver;
  logic [31:0] dst_addr;
  logic        pkt_dir;
  logic [7:0]  pkt_port;
  logic [63:0] ingress_cnt;
  logic [63:0] egress_cnt;

  // accepted input item, unpacked
  in_data_t    in_item;

  // blocklist
  logic [31:0] blk_addr  [TABLE_ENTRIES];
  logic        blk_valid [TABLE_ENTRIES];

  function automatic int find_blocked(logic [31:0] a);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (blk_valid[i] && blk_addr[i] == a) return i;
    end
    return -1;
  endfunction

  task automatic post_ack(status_e st);
    filter_result_t r;
    r.kind = KIND_ACK;
    r.data = '0;
    r.data.table_status = st;
    results_due.push_back(r);
  endtask

  task automatic edit_blocklist(req_e req, logic [31:0] a);
    int hit;
    int slot;
    hit  = find_blocked(a);
    slot = -1;
    if (req == REQ_ADD) begin
      if (hit >= 0) begin
        post_ack(ST_OK);
      end else begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (!blk_valid[i] && slot < 0) slot = i;
        end
        if (slot < 0) begin
          post_ack(ST_FULL);
        end else begin
          blk_valid[slot] = 1'b1;
          blk_addr[slot]  = a;
          post_ack(ST_OK);
        end
      end
    end else if (hit >= 0) begin
      blk_valid[hit] = 1'b0;
      post_ack(ST_OK);
    end else begin
      post_ack(ST_MISS);
    end
  endtask

  task automatic parse_byte(in_data_t d, logic last);
    logic [15:0]    p;
    logic [15:0]    l3;
    logic [15:0]    len;
    filter_result_t r;
    p = byte_pos;
    if (p == 16'd0) begin
      pkt_dir  = d.direction;
      pkt_port = d.port_index;
      eth_type = '0;
      tag_seen = 1'b0;
      ip_ver   = '0;
      dst_addr = '0;
    end
    if (p == OFS_TYPE_HI || (tag_seen && p == OFS_TAG_HI)) eth_type[15:8] = d.pkt_byte;
    if (p == OFS_TYPE_LO || (tag_seen && p == OFS_TAG_LO)) eth_type[7:0]  = d.pkt_byte;
    if (p == OFS_TYPE_LO && (eth_type == ETH_VLAN_Q || eth_type == ETH_VLAN_AD))
      tag_seen = 1'b1;
    l3 = tag_seen ? L3_TAG : L3_UNTAG;
    if (p == l3) ip_ver = d.pkt_byte[7:4];
    if (p >= l3 + OFS_DST && p <= l3 + OFS_DST_END) dst_addr = {dst_addr[23:0], d.pkt_byte};
    if (byte_pos != POS_MAX) byte_pos = byte_pos + 16'd1;
    if (!last) return;

    len = byte_pos;
    r.kind = KIND_VERDICT;
    r.data = '0;
    r.data.drop = pkt_dir && len >= l3 + L3_MIN_LEN && eth_type == ETH_IPV4 &&
                  ip_ver == IP_VER4 && find_blocked(dst_addr) >= 0;
    if (pkt_dir) begin
      egress_cnt = egress_cnt + 64'd1;
      r.data.pkt_count = egress_cnt;
    end else begin
      ingress_cnt = ingress_cnt + 64'd1;
      r.data.pkt_count = ingress_cnt;
    end
    r.data.out_direction = pkt_dir;
    r.data.out_port      = pkt_port;
    r.data.pkt_len       = len;
    r.data.cap_len       = (len > CAPTURE_MAX) ? CAPTURE_MAX[7:0] : len[7:0];
    results_due.push_back(r);
    byte_pos = '0;
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_count_o++;
    end
  endtask

  task automatic check_result();
    filter_result_t r;
    out_data_t      got;
    got = out_data_t'(m_tdata_i);
    if (results_due.size() == 0) begin
      $error("result with nothing expected: kind %0d data %0h", m_tuser_i[0], m_tdata_i);
      fail_count_o++;
      return;
    end
    r = results_due.pop_front();
    if (r.kind == KIND_ACK) acks_o++;
    else verdicts_o++;
    check_field("result_kind",   r.kind,                 m_tuser_i[0]);
    check_field("drop",          r.data.drop,            got.drop);
    check_field("out_direction", r.data.out_direction,   got.out_direction);
    check_field("out_port",      r.data.out_port,        got.out_port);
    check_field("pkt_len",       r.data.pkt_len,         got.pkt_len);
    check_field("cap_len",       r.data.cap_len,         got.cap_len);
    check_field("pkt_count",     r.data.pkt_count,       got.pkt_count);
    check_field("table_status",  r.data.table_status,    got.table_status);
  endtask

  // Sample mid-cycle: both sides only change at the rising edge.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      byte_pos     = '0;
      eth_type     = '0;
      tag_seen     = 1'b0;
      ip_ver       = '0;
      dst_addr     = '0;
      pkt_dir      = 1'b0;
      pkt_port     = '0;
      ingress_cnt  = '0;
      egress_cnt   = '0;
      fail_count_o = 0;
      verdicts_o   = 0;
      acks_o       = 0;
      results_due.delete();
      for (int i = 0; i < TABLE_ENTRIES; i++) blk_valid[i] = 1'b0;
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        in_item = in_data_t'(s_tdata_i);
        case (req_e'(s_tuser_i))
          REQ_PKT:          parse_byte(in_item, s_tlast_i);
          REQ_ADD, REQ_DEL: edit_blocklist(req_e'(s_tuser_i), in_item.blocked_addr);
          default: ;
        endcase
      end
      if (m_tvalid_i && m_tready_i) check_result();
    end
    pending_o = results_due.size();
  end

endmodule

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import edbf_pkg::*;

  localparam int unsigned TABLE_ENTRIES  = 16;
  localparam int unsigned WATCHDOG_LIMIT = 2000;   // cycles with no item moving either way
  localparam int unsigned PHASE_ITEMS    = 70;     // random items per idling mix
  localparam int unsigned PHASE_RESULTS  = 4;      // keep going until this many results too
  localparam int unsigned DRAIN_CYCLES   = 8;      // pipe is 2 deep, give it some slack
  localparam int unsigned POOL_SIZE      = 20;     // more than TABLE_ENTRIES so the table fills

  localparam logic [1:0]  REQ_UNKNOWN = 2'd3;
  localparam logic [15:0] NO_TAG      = 16'h0000;
  localparam logic [15:0] ETH_IPV6    = 16'h86DD;
  localparam logic [15:0] ETH_ARP     = 16'h0806;

  typedef enum int {FR_IPV4, FR_OTHER_TYPE, FR_BAD_VER, FR_NOISE} frame_kind_e;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;
  logic                   s_axis_tlast  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;

  int fail_count;
  int pending;
  int verdicts;
  int acks;

  // Idling knobs, percent of cycles: sender gaps and receiver stalls.
  int unsigned idle_pct  = 17;
  int unsigned stall_pct = 54;

  int unsigned items_sent      = 0;  // accepted items, ignored requests not counted
  int unsigned results_planned = 0;
  int unsigned stuck_cycles    = 0;

  logic [7:0]  frame_bytes[$];
  logic [31:0] addr_pool[POOL_SIZE];

  egress_ipv4_dest_blocklist_filter_top #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  blocklist_filter_checker #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) filter_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .s_tlast_i   (s_axis_tlast),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .m_tuser_i   (m_axis_tuser),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .verdicts_o  (verdicts),
    .acks_o      (acks)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Reset once at start-up, then released.
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Receiver backpressure, redrawn every cycle.
  always @(posedge clk_i) begin
    m_axis_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: a hang shows up as a long run of cycles where nothing moves.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: nothing moved for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, pending);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // One item on the input stream. Random gaps go in front of it; the
  // handshake is sampled at the falling edge where everything is settled.
  task automatic send_item(logic [1:0] req, logic [7:0] b, logic last, logic dir,
                           logic [7:0] port, logic [31:0] addr);
    in_data_t d;
    logic     taken;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    d              = '0;
    d.pkt_byte     = b;
    d.direction    = dir;
    d.port_index   = port;
    d.blocked_addr = addr;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= req;
    s_axis_tlast  <= last;
    do begin
      @(negedge clk_i);
      taken = s_axis_tready;
      @(posedge clk_i);
    end while (!taken);
    if (req != REQ_UNKNOWN) items_sent++;
  endtask

  // Table request; the packet fields carry junk since the block ignores them.
  task automatic send_op(req_e req, logic [31:0] addr);
    send_item(req, 8'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)),
              8'($urandom), addr);
    results_planned++;
  endtask

  // Pressure: hold the sender off until every result is back.
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Builds a frame in frame_bytes: MACs, optional tag, EtherType, IPv4
  // header with dst at L3+16, payload, then cut or padded to len.
  function automatic void build_frame(frame_kind_e kind, logic [15:0] tag_type,
                                      logic [31:0] dst, int unsigned len);
    logic [15:0] et;
    logic [3:0]  ver;
    frame_bytes.delete();
    repeat (12) frame_bytes.push_back(8'($urandom));
    if (tag_type != NO_TAG) begin
      frame_bytes.push_back(tag_type[15:8]);
      frame_bytes.push_back(tag_type[7:0]);
      repeat (2) frame_bytes.push_back(8'($urandom));
    end
    case (kind)
      FR_OTHER_TYPE: begin
        case ($urandom_range(2))
          0:       et = ETH_IPV6;
          1:       et = ETH_ARP;
          default: et = 16'($urandom);
        endcase
        if (et == ETH_IPV4) et = ETH_IPV6;
      end
      default: et = ETH_IPV4;
    endcase
    ver = IP_VER4;
    if (kind == FR_BAD_VER) begin
      ver = 4'($urandom_range(15));
      if (ver == IP_VER4) ver = ver + 4'd2;
    end
    frame_bytes.push_back(et[15:8]);
    frame_bytes.push_back(et[7:0]);
    frame_bytes.push_back({ver, 4'h5});
    repeat (15) frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(dst[31:24]);
    frame_bytes.push_back(dst[23:16]);
    frame_bytes.push_back(dst[15:8]);
    frame_bytes.push_back(dst[7:0]);
    while (frame_bytes.size() < len) frame_bytes.push_back(8'($urandom));
    while (frame_bytes.size() > len) void'(frame_bytes.pop_back());
    if (kind == FR_NOISE) foreach (frame_bytes[i]) frame_bytes[i] = 8'($urandom);
  endfunction

  // Streams frame_bytes; a table request can be slipped in before byte edit_at
  // so the verdict sees the table as it stands at the last byte.
  task automatic send_frame(logic dir, logic [7:0] port, int edit_at, req_e edit_req,
                            logic [31:0] edit_addr);
    for (int i = 0; i < frame_bytes.size(); i++) begin
      if (i == edit_at) send_op(edit_req, edit_addr);
      send_item(REQ_PKT, frame_bytes[i], i == frame_bytes.size() - 1, dir, port, $urandom);
    end
    results_planned++;
  endtask

  task automatic run_directed();
    logic [31:0] addr_a;
    logic [31:0] addr_b;
    addr_a = addr_pool[2];
    addr_b = addr_pool[3];
    // table edits on an empty table, then a duplicate add
    send_op(REQ_DEL, addr_a);
    send_op(REQ_ADD, addr_a);
    send_op(REQ_ADD, addr_a);
    // shortest frame that still carries the whole dst: egress drops, ingress passes
    build_frame(FR_IPV4, NO_TAG, addr_a, 34);
    send_frame(1'b1, 8'hFF, -1, REQ_ADD, '0);
    send_frame(1'b0, 8'h00, -1, REQ_ADD, '0);
    // one byte short of the dst
    build_frame(FR_IPV4, NO_TAG, addr_a, 33);
    send_frame(1'b1, 8'h11, -1, REQ_ADD, '0);
    // both tag kinds, and a tagged frame cut short
    build_frame(FR_IPV4, ETH_VLAN_Q, addr_a, 38);
    send_frame(1'b1, 8'h22, -1, REQ_ADD, '0);
    build_frame(FR_IPV4, ETH_VLAN_AD, addr_a, 38);
    send_frame(1'b1, 8'h33, -1, REQ_ADD, '0);
    build_frame(FR_IPV4, ETH_VLAN_Q, addr_a, 37);
    send_frame(1'b1, 8'h44, -1, REQ_ADD, '0);
    // wrong IP version, non-IPv4 EtherType, single-byte frame
    build_frame(FR_BAD_VER, NO_TAG, addr_a, 34);
    send_frame(1'b1, 8'h55, -1, REQ_ADD, '0);
    build_frame(FR_OTHER_TYPE, NO_TAG, addr_a, 34);
    send_frame(1'b1, 8'h66, -1, REQ_ADD, '0);
    build_frame(FR_IPV4, NO_TAG, addr_a, 1);
    send_frame(1'b1, 8'h77, -1, REQ_ADD, '0);
    // unknown request type: no result
    send_item(REQ_UNKNOWN, 8'hA5, 1'b1, 1'b1, 8'h5A, addr_a);
    // add mid-frame makes it drop, remove mid-frame lets it pass
    build_frame(FR_IPV4, NO_TAG, addr_b, 34);
    send_frame(1'b1, 8'h5A, 20, REQ_ADD, addr_b);
    send_frame(1'b1, 8'h5A, 30, REQ_DEL, addr_b);
    // fill the table (address extremes included), overflow it, then remove twice
    send_op(REQ_ADD, addr_pool[0]);
    send_op(REQ_ADD, addr_pool[1]);
    for (int i = 4; i < 4 + TABLE_ENTRIES - 3; i++) send_op(REQ_ADD, addr_pool[i]);
    send_op(REQ_ADD, addr_pool[POOL_SIZE - 1]);
    send_op(REQ_DEL, addr_a);
    send_op(REQ_DEL, addr_a);
  endtask

  // Random traffic: table requests and frames, mostly aimed at the address pool, with
  // short frames, other EtherTypes, bad versions, plain noise and unknown requests.
  task automatic run_random(int unsigned n_items, int unsigned n_results);
    int unsigned start_items;
    int unsigned start_results;
    int unsigned r;
    int unsigned len;
    int unsigned l3;
    int          edit_at;
    logic [15:0] tag;
    logic [31:0] dst;
    frame_kind_e kind;
    start_items   = items_sent;
    start_results = results_planned;
    while (items_sent - start_items < n_items || results_planned - start_results < n_results) begin
      r = $urandom_range(99);
      if (r < 42) begin
        send_op($urandom_range(99) < 55 ? REQ_ADD : REQ_DEL,
                $urandom_range(9) == 0 ? $urandom :
                                         addr_pool[5'($urandom_range(POOL_SIZE - 1))]);
      end else if (r < 46) begin
        send_item(REQ_UNKNOWN, 8'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  8'($urandom), $urandom);
      end else if (r < 48) begin
        wait_drain();
      end else begin
        r = $urandom_range(99);
        kind = (r < 60) ? FR_IPV4 : (r < 75) ? FR_OTHER_TYPE : (r < 85) ? FR_BAD_VER : FR_NOISE;
        tag  = NO_TAG;
        if ($urandom_range(99) < 30) tag = $urandom_range(1) ? ETH_VLAN_Q : ETH_VLAN_AD;
        l3   = 32'((tag == NO_TAG) ? L3_UNTAG : L3_TAG);
        if ($urandom_range(99) < 80) len = l3 + L3_MIN_LEN + $urandom_range(4);
        else len = $urandom_range(l3 + L3_MIN_LEN - 1, 1);
        dst = ($urandom_range(99) < 75) ? addr_pool[5'($urandom_range(POOL_SIZE - 1))] :
                                          $urandom;
        build_frame(kind, tag, dst, len);
        edit_at = ($urandom_range(9) == 0) ? $urandom_range(len - 1) : -1;
        send_frame($urandom_range(99) < 65, 8'($urandom), edit_at,
                   $urandom_range(1) ? REQ_ADD : REQ_DEL, dst);
      end
    end
  endtask

  initial begin
    addr_pool[0] = 32'h0000_0000;
    addr_pool[1] = 32'hFFFF_FFFF;
    addr_pool[2] = 32'hC0A8_0001;
    addr_pool[3] = 32'h0A00_0002;
    for (int i = 4; i < POOL_SIZE; i++) addr_pool[i] = $urandom;

    wait (rst_ni);
    @(posedge clk_i);

    // mix 1: light sender gaps, heavy receiver stalls
    idle_pct  = 17;
    stall_pct = 54;
    run_directed();
    wait_drain();
    run_random(PHASE_ITEMS, PHASE_RESULTS);
    wait_drain();

    // mix 2: the other way round
    idle_pct  = 54;
    stall_pct = 17;
    run_random(PHASE_ITEMS, PHASE_RESULTS);
    wait_drain();

    // mix 3: back to back both ways
    idle_pct  = 0;
    stall_pct = 0;
    run_random(PHASE_ITEMS, PHASE_RESULTS);

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d items in; %0d verdicts and %0d table replies compared,",
             items_sent, verdicts, acks);
    $display("  across three idling mixes, tagged and short frames and a full table");
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/edbf_pkg.sv
sv/egress_ipv4_dest_blocklist_filter_top.sv
sv/edbf_checker.sv
tb/blocklist_filter_checker.sv
tb/testbench.sv
